>>> rtl/assert_macros.svh
// Assertion helpers for the strip hit builder.
// Both forms sample on clk; the first one is masked while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SLH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SLH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SLH_ASSERT(lbl, prop, msg)

`define SLH_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> rtl/slh_pkg.sv
package slh_pkg;

  localparam int STRIPS   = 48;
  localparam int STRIP_AW = (STRIPS > 1) ? $clog2(STRIPS) : 1;
  localparam int KILL_W   = 48;

  localparam int STRIP_W  = 6;
  localparam int TIME_W   = 24;
  localparam int WIDTH_W  = 16;
  localparam int CORR_W   = 16;
  localparam int PTIME_W  = 26;
  localparam int SUM_W    = 27;
  localparam int DIFF_W   = 26;
  localparam int WSUM_W   = 17;
  localparam int CNT_W    = 8;
  localparam int WIN_W    = 16;
  localparam int MODE_W   = 2;
  localparam int DEAD_W   = 2;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 88;
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 48;

  localparam logic [MODE_W-1:0] MODE_DIGIT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CORR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  localparam logic [DEAD_W-1:0] DEAD_NONE  = 2'd0;
  localparam logic [DEAD_W-1:0] DEAD_LEFT  = 2'd1;
  localparam logic [DEAD_W-1:0] DEAD_RIGHT = 2'd2;

  localparam logic [CFG_AW-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_AW-1:0] REG_DEAD   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_KILL   = 2'd2;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd2212;
  localparam logic [CNT_W-1:0] CNT_MAX      = 8'd255;

  // One strip's pending left/right times and widths.
  typedef struct packed {
    logic signed [PTIME_W-1:0] lt;
    logic signed [PTIME_W-1:0] rt;
    logic [WIDTH_W-1:0]        lw;
    logic [WIDTH_W-1:0]        rw;
  } pend_entry_t;

  // Access request to the pending-entry store.
  typedef struct packed {
    logic                rd_en;
    logic [STRIP_AW-1:0] rd_addr;
    logic                wr_en;
    logic [STRIP_AW-1:0] wr_addr;
    logic                clear;
  } pend_req_t;

endpackage

>>> rtl/strip_lr_hit_builder.sv
// Left/right coincidence hit builder for double-ended strips. Each input
// transfer carries a mode in in_tuser: a readout digit, a correction load, an
// event clear or an event readout. Per-strip pending times and widths live in
// one synchronous memory, the per-strip corrections in a second one;
// hit-latched and reportable flags are kept in flip-flops. A digit passes
// through memory read, pending update, then coincidence test with write-back
// and result, the read-modify-write of its strip entry. A correction load
// or an event clear gives no result. A readout walks the strip index one
// step per cycle up to the last reportable strip and stops on each reported
// hit for the memory read and an emit step; an empty event answers with a
// single empty result. Results wait in an output register, and a stalled
// out_tready holds the block in any state that must load a result.
// Configuration writes are taken at any time through the cfg_we port and
// must only occur while the block is idle.
`include "assert_macros.svh"

module strip_lr_hit_builder (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata, low bit up: digit_strip[5:0], digit_side[6], digit_time[30:7],
  // digit_width[46:31], correction[62:47], zero pad[63]
  input  logic [slh_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser: mode[1:0]
  input  logic [slh_pkg::MODE_W-1:0]       in_tuser,
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata, low bit up: accepted[0], hit_valid[1], hit_strip[7:2],
  // time_sum[34:8], time_diff[60:35], width_sum[77:61], hit_count[85:78],
  // zero pad[87:86]
  output logic [slh_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [slh_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [slh_pkg::CFG_DW-1:0]       cfg_wdata
);
  import slh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DG_MOD,
    S_DG_CMP,
    S_RO_SCAN,
    S_RO_EMIT,
    S_RO_EMPTY
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [WIN_W-1:0]  win_r;
  logic [DEAD_W-1:0] dead_r;
  logic [KILL_W-1:0] kill_r;

  // Per-strip flags
  logic [STRIPS-1:0] hit_latched_r;
  logic [STRIPS-1:0] report_r;      // latched with both widths nonzero
  logic [CNT_W-1:0]  hit_total_r;

  // Digit in flight
  logic [STRIP_AW-1:0] strip_r;
  logic                in_range_r;
  logic                side_r;
  logic [TIME_W-1:0]   time_r;
  logic [WIDTH_W-1:0]  width_r;
  logic                was_latched_r;
  pend_entry_t         new_r;

  // Readout walk
  logic [STRIP_AW-1:0] idx_r;

  // Output register
  logic                     out_valid_r;
  logic                     o_acc_r;
  logic                     o_hv_r;
  logic [STRIP_W-1:0]       o_strip_r;
  logic signed [SUM_W-1:0]  o_tsum_r;
  logic signed [DIFF_W-1:0] o_tdiff_r;
  logic [WSUM_W-1:0]        o_wsum_r;
  logic [CNT_W-1:0]         o_cnt_r;
  logic                     o_last_r;

  // Input unpacking
  logic [MODE_W-1:0]        in_mode;
  logic [STRIP_W-1:0]       in_strip;
  logic                     in_side;
  logic [TIME_W-1:0]        in_time;
  logic [WIDTH_W-1:0]       in_width;
  logic signed [CORR_W-1:0] in_corr;
  logic                     in_fire;
  logic                     in_range;
  logic [STRIP_AW-1:0]      in_addr;

  assign in_mode  = in_tuser;
  assign in_strip = in_tdata[5:0];
  assign in_side  = in_tdata[6];
  assign in_time  = in_tdata[30:7];
  assign in_width = in_tdata[46:31];
  assign in_corr  = $signed(in_tdata[62:47]);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire  = in_tvalid && in_tready;
  assign in_range = (int'(in_strip) < STRIPS);
  assign in_addr  = in_strip[STRIP_AW-1:0];

  logic out_free;
  logic out_load;
  assign out_free = !out_valid_r || out_tready;
  // A result loads into the output register this cycle.
  assign out_load = out_free && ((state_r == S_DG_CMP) || (state_r == S_RO_EMIT) ||
                                 (state_r == S_RO_EMPTY));

  // Memories
  pend_req_t                pend_req;
  pend_entry_t              pend_rd;
  logic signed [CORR_W-1:0] corr_rd;
  logic                     digit_rd;

  assign digit_rd = in_fire && (in_mode == MODE_DIGIT) && in_range;

  always_comb begin
    pend_req.rd_en   = digit_rd || ((state_r == S_RO_SCAN) && report_r[idx_r]);
    pend_req.rd_addr = (state_r == S_IDLE) ? in_addr : idx_r;
    pend_req.wr_en   = (state_r == S_DG_CMP) && out_free && in_range_r && !was_latched_r;
    pend_req.wr_addr = strip_r;
    pend_req.clear   = in_fire && (in_mode == MODE_CLEAR);
  end

  slh_pend_store u_pend (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (pend_req),
    .wr_data (new_r),
    .rd_data (pend_rd)
  );

  slh_corr_store u_corr (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_fire && (in_mode == MODE_CORR) && in_range),
    .wr_addr (in_addr),
    .wr_data (in_corr),
    .rd_en   (digit_rd),
    .rd_addr (in_addr),
    .rd_data (corr_rd)
  );

  // Pending update: apply the digit to the entry just read. A killed strip
  // or a latched strip keeps its old values; a live side feeds the dead one.
  logic signed [PTIME_W-1:0] corr_ext;
  logic signed [PTIME_W-1:0] time_ext;
  logic signed [PTIME_W-1:0] left_new;
  logic                      kill_hit;
  logic                      cur_latched;
  pend_entry_t               upd;

  always_comb begin
    corr_ext    = PTIME_W'(corr_rd);
    time_ext    = $signed({2'b00, time_r});
    left_new    = time_ext - (corr_ext <<< 1);
    kill_hit    = (int'(strip_r) < KILL_W) && kill_r[strip_r];
    cur_latched = in_range_r && hit_latched_r[strip_r];
    upd         = pend_rd;
    if (in_range_r && !cur_latched && !kill_hit) begin
      if (!side_r && (dead_r != DEAD_LEFT)) begin
        upd.lt = left_new;
        upd.lw = width_r;
        if (dead_r == DEAD_RIGHT) begin
          upd.rt = left_new;
          upd.rw = width_r;
        end
      end
      if (side_r && (dead_r != DEAD_RIGHT)) begin
        upd.rt = time_ext;
        upd.rw = width_r;
        if (dead_r == DEAD_LEFT) begin
          upd.lt = time_ext;
          upd.lw = width_r;
        end
      end
    end
  end

  // Coincidence test on the updated entry
  logic signed [SUM_W-1:0] lr_diff;
  logic [SUM_W-1:0]        lr_abs;
  logic                    latch_now;

  always_comb begin
    lr_diff   = SUM_W'(new_r.lt) - SUM_W'(new_r.rt);
    lr_abs    = lr_diff[SUM_W-1] ? SUM_W'(-lr_diff) : SUM_W'(lr_diff);
    latch_now = in_range_r && !was_latched_r && (new_r.lt != '0) && (new_r.rt != '0) &&
                (lr_abs <= SUM_W'(win_r));
  end

  // Readout result from the entry read at idx_r
  logic signed [SUM_W-1:0] ro_sum;
  logic signed [SUM_W-1:0] ro_diff;
  logic [WSUM_W-1:0]       ro_wsum;
  logic [CNT_W-1:0]        total_inc;
  logic                    more_above;

  always_comb begin
    ro_sum    = SUM_W'(pend_rd.lt) + SUM_W'(pend_rd.rt);
    ro_diff   = SUM_W'(pend_rd.lt) - SUM_W'(pend_rd.rt);
    ro_wsum   = {1'b0, pend_rd.lw} + {1'b0, pend_rd.rw};
    total_inc = (hit_total_r != CNT_MAX) ? hit_total_r + 1'b1 : hit_total_r;
    more_above = 1'b0;
    for (int j = 0; j < STRIPS; j++) begin
      if ((j > int'(idx_r)) && report_r[j]) begin
        more_above = 1'b1;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= WINDOW_RESET;
      dead_r <= DEAD_NONE;
      kill_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WINDOW: win_r  <= cfg_wdata[WIN_W-1:0];
        REG_DEAD:   dead_r <= cfg_wdata[DEAD_W-1:0];
        REG_KILL:   kill_r <= cfg_wdata[KILL_W-1:0];
        default:    ;
      endcase
    end
  end

  // Payload registers of the digit in flight
  always_ff @(posedge clk) begin
    if (in_fire) begin
      strip_r <= in_addr;
      side_r  <= in_side;
      time_r  <= in_time;
      width_r <= in_width;
    end
    if (state_r == S_DG_MOD) begin
      new_r         <= upd;
      was_latched_r <= cur_latched;
    end
  end

  // Control sequencer with output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      hit_latched_r <= '0;
      report_r      <= '0;
      hit_total_r   <= '0;
      idx_r         <= '0;
      in_range_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      // Drop a result once it has been taken, unless a new one loads behind it.
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            in_range_r <= in_range;
            case (in_mode)
              MODE_DIGIT: state_r <= S_DG_MOD;
              MODE_CLEAR: begin
                hit_latched_r <= '0;
                report_r      <= '0;
                hit_total_r   <= '0;
              end
              MODE_READ: begin
                idx_r   <= '0;
                state_r <= (report_r == '0) ? S_RO_EMPTY : S_RO_SCAN;
              end
              default: ;
            endcase
          end
        end

        S_DG_MOD: state_r <= S_DG_CMP;

        S_DG_CMP: begin
          // Hold the write-back until the result can be loaded.
          if (out_free) begin
            if (latch_now) begin
              hit_latched_r[strip_r] <= 1'b1;
              report_r[strip_r]      <= (new_r.lw != '0) && (new_r.rw != '0);
            end
            out_valid_r <= 1'b1;
            o_acc_r     <= in_range_r && (was_latched_r || latch_now);
            o_hv_r      <= 1'b0;
            o_strip_r   <= '0;
            o_tsum_r    <= '0;
            o_tdiff_r   <= '0;
            o_wsum_r    <= '0;
            o_cnt_r     <= '0;
            o_last_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end

        S_RO_SCAN: begin
          // Advance past strips with nothing to report.
          if (report_r[idx_r]) begin
            state_r <= S_RO_EMIT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end

        S_RO_EMIT: begin
          if (out_free) begin
            hit_total_r <= total_inc;
            out_valid_r <= 1'b1;
            o_acc_r     <= 1'b0;
            o_hv_r      <= 1'b1;
            o_strip_r   <= STRIP_W'(idx_r);
            o_tsum_r    <= ro_sum;
            o_tdiff_r   <= ro_diff[DIFF_W-1:0];
            o_wsum_r    <= ro_wsum;
            o_cnt_r     <= total_inc;
            o_last_r    <= !more_above;
            if (more_above) begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_RO_SCAN;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end

        S_RO_EMPTY: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_acc_r     <= 1'b0;
            o_hv_r      <= 1'b0;
            o_strip_r   <= '0;
            o_tsum_r    <= '0;
            o_tdiff_r   <= '0;
            o_wsum_r    <= '0;
            o_cnt_r     <= hit_total_r;
            o_last_r    <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {2'b00, o_cnt_r, o_wsum_r, o_tdiff_r, o_tsum_r, o_strip_r,
                       o_hv_r, o_acc_r};

  // A reportable strip must also be latched.
  `SLH_ASSERT(a_report_latched, ((report_r & ~hit_latched_r) == '0), "reportable strip not latched")

  // The walk only stops on a strip that has something to report.
  `SLH_ASSERT(a_emit_on_hit, ((state_r == S_RO_EMIT) |-> report_r[idx_r]), "empty strip emitted")

  // The hit total only moves down through an event clear.
  `SLH_ASSERT(a_total_up, (!pend_req.clear |=> (hit_total_r >= $past(hit_total_r))), "hit total fell")

endmodule

>>> rtl/slh_pend_store.sv
module slh_pend_store (
  input  logic                clk,
  input  logic                rst_n,
  input  slh_pkg::pend_req_t   req,
  input  slh_pkg::pend_entry_t wr_data,
  output slh_pkg::pend_entry_t rd_data
);
  import slh_pkg::*;

  pend_entry_t       mem [STRIPS];
  pend_entry_t       rd_q_r;
  logic [STRIPS-1:0] vld_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  // Entry valid bits: an entry never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.clear) begin
        vld_r <= '0;
      end else if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

>>> rtl/slh_corr_store.sv
module slh_corr_store (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [slh_pkg::STRIP_AW-1:0]        wr_addr,
  input  logic signed [slh_pkg::CORR_W-1:0]   wr_data,
  input  logic                                rd_en,
  input  logic [slh_pkg::STRIP_AW-1:0]        rd_addr,
  output logic signed [slh_pkg::CORR_W-1:0]   rd_data
);
  import slh_pkg::*;

  logic signed [CORR_W-1:0] mem [STRIPS];
  logic signed [CORR_W-1:0] rd_q_r;
  logic [STRIPS-1:0]        vld_r;
  logic                     rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Corrections survive an event clear; only reset drops them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule
